### rtl/core/cpram_pkg.sv
package cpram_pkg;

  localparam int unsigned PaletteCount    = 8;
  localparam int unsigned ColorsPerPal    = 4;
  localparam int unsigned WordsPerMem     = PaletteCount * ColorsPerPal;
  localparam int unsigned WordAddrWidth   = $clog2(WordsPerMem);
  localparam int unsigned WordWidth       = 16;
  localparam int unsigned ByteWidth       = 8;
  localparam int unsigned RgbaWidth       = 32;
  localparam int unsigned ChannelWidth    = 5;

  localparam logic [ByteWidth-1:0] AlphaOpaque = 8'hFF;

  localparam int unsigned IdxHighBit    = 0;
  localparam int unsigned IdxAutoIncBit = 7;
  localparam int unsigned IdxCountWidth = 6;

  typedef enum logic [1:0] {
    CMD_WRITE_INDEX = 2'd0,
    CMD_WRITE_DATA  = 2'd1,
    CMD_READ_DATA   = 2'd2,
    CMD_LOOKUP      = 2'd3
  } command_t;

  typedef logic [WordWidth-1:0] word_t;

  function automatic logic [RgbaWidth-1:0] expand_color(input word_t word);
    logic [ByteWidth-1:0] red;
    logic [ByteWidth-1:0] green;
    logic [ByteWidth-1:0] blue;
    red   = {word[ChannelWidth-1:0], 3'b000};
    green = {word[2*ChannelWidth-1:ChannelWidth], 3'b000};
    blue  = {word[3*ChannelWidth-1:2*ChannelWidth], 3'b000};
    return {red, green, blue, AlphaOpaque};
  endfunction

endpackage

### rtl/core/color_palette_ram_auto_index_unit.sv
// Palette memory block with a background and an object memory, each holding 8 palettes
// of 4 BGR555 colours in 16-bit words, addressed byte-wise through an index register with
// optional auto-increment. Every beat carries one command: index write, data byte write,
// data byte read or colour lookup (RGBA, 8 bits a channel, alpha 255), and gives exactly
// one result beat. One beat is taken every cycle unless a stalled result holds the input
// register; a beat passes the input register and then the result register. The
// palette words sit in flip-flops that reset clears, read through one 32-way word select
// per cycle, so a data write is read, merged and written back within its single pass.
module color_palette_ram_auto_index_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           command,
  input  logic                                 target,
  input  logic [7:0]                           data_byte,
  input  logic [2:0]                           palette_number,
  input  logic [1:0]                           color_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           read_byte,
  output logic [cpram_pkg::RgbaWidth-1:0]      color_rgba,
  output logic [7:0]                           index_value
);
  import cpram_pkg::*;

  word_t bg_mem [WordsPerMem];
  word_t obj_mem [WordsPerMem];
  logic [ByteWidth-1:0] bg_idx;
  logic [ByteWidth-1:0] obj_idx;

  logic                 s1_valid;
  command_t             s1_cmd;
  logic                 s1_target;
  logic [ByteWidth-1:0] s1_data;
  logic [2:0]           s1_pal;
  logic [1:0]           s1_col;

  logic out_adv;
  logic go;

  logic [ByteWidth-1:0]     sel_idx;
  logic [WordAddrWidth-1:0] idx_addr;
  logic [WordAddrWidth-1:0] rd_addr;
  word_t                    rd_word;
  word_t                    merged;
  logic [ByteWidth-1:0]     idx_next;
  logic [ByteWidth-1:0]     read_byte_next;
  logic [RgbaWidth-1:0]     color_next;

  assign out_adv  = !out_valid || !out_stall;
  assign go       = s1_valid && out_adv;
  assign in_stall = s1_valid && !out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd    <= command_t'(command);
      s1_target <= target;
      s1_data   <= data_byte;
      s1_pal    <= palette_number;
      s1_col    <= color_number;
    end
  end

  // single pass over the registered beat
  always_comb begin
    sel_idx  = s1_target ? obj_idx : bg_idx;
    idx_addr = sel_idx[WordAddrWidth:1];
    rd_addr  = (s1_cmd == CMD_LOOKUP) ? {s1_pal, s1_col} : idx_addr;
    rd_word  = s1_target ? obj_mem[rd_addr] : bg_mem[rd_addr];

    if (sel_idx[IdxHighBit]) begin
      merged = {s1_data, rd_word[ByteWidth-1:0]};
    end else begin
      merged = {rd_word[WordWidth-1:ByteWidth], s1_data};
    end

    idx_next       = sel_idx;
    read_byte_next = '0;
    color_next     = '0;
    case (s1_cmd)
      CMD_WRITE_INDEX: begin
        idx_next = s1_data;
      end
      CMD_WRITE_DATA: begin
        color_next = expand_color(merged);
        if (sel_idx[IdxAutoIncBit]) begin
          idx_next = {sel_idx[ByteWidth-1:IdxCountWidth],
                      sel_idx[IdxCountWidth-1:0] + IdxCountWidth'(1)};
        end
      end
      CMD_READ_DATA: begin
        read_byte_next = sel_idx[IdxHighBit] ? rd_word[WordWidth-1:ByteWidth]
                                             : rd_word[ByteWidth-1:0];
      end
      CMD_LOOKUP: begin
        color_next = expand_color(rd_word);
      end
      default: begin
        idx_next = sel_idx;
      end
    endcase
  end

  // palette words and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_idx  <= '0;
      obj_idx <= '0;
      for (int i = 0; i < WordsPerMem; i++) begin
        bg_mem[i]  <= '0;
        obj_mem[i] <= '0;
      end
    end else if (go) begin
      if (s1_target) begin
        obj_idx <= idx_next;
      end else begin
        bg_idx <= idx_next;
      end
      if (s1_cmd == CMD_WRITE_DATA) begin
        if (s1_target) begin
          obj_mem[idx_addr] <= merged;
        end else begin
          bg_mem[idx_addr] <= merged;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_byte   <= read_byte_next;
      color_rgba  <= color_next;
      index_value <= idx_next;
    end
  end

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_adv) |=> s1_valid)
    else $error("input register dropped a held beat");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (go && s1_cmd != CMD_READ_DATA) |=> (read_byte == '0))
    else $error("read byte not zero outside a read");

  a_lookup_keeps_index: assert property (@(posedge clk) disable iff (rst)
    (go && s1_cmd == CMD_LOOKUP) |=> ($stable(bg_idx) && $stable(obj_idx)))
    else $error("lookup changed an index register");

  a_inc_keeps_top: assert property (@(posedge clk) disable iff (rst)
    (go && s1_cmd == CMD_WRITE_DATA) |=>
      (index_value[ByteWidth-1:IdxCountWidth] ==
       $past(sel_idx[ByteWidth-1:IdxCountWidth])))
    else $error("data write altered index bits 6 and 7");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (go && (s1_cmd == CMD_WRITE_DATA || s1_cmd == CMD_LOOKUP)) |=>
      (color_rgba[ByteWidth-1:0] == AlphaOpaque))
    else $error("colour result without opaque alpha");

endmodule

### tb/tb_color_palette_ram_auto_index_unit.sv
module tb_color_palette_ram_auto_index_unit;
  import cpram_pkg::*;

  typedef struct packed {
    command_t   cmd;
    logic       target;
    logic [7:0] data;
    logic [2:0] pal;
    logic [1:0] col;
  } palette_beat_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [31:0] color_rgba;
    logic [7:0]  index_value;
  } palette_result_t;

  localparam int RandomItems  = 1750;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 10;
  localparam int ReportLimit  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_WRITE_INDEX;
  logic        target = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic [2:0]  palette_number = 3'd0;
  logic [1:0]  color_number = 2'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_byte;
  logic [31:0] color_rgba;
  logic [7:0]  index_value;

  // palette state mirror, indexed by target
  logic [15:0] pal_words [2][32];
  logic [7:0]  pal_index [2];

  palette_beat_t   beat_q [$];
  palette_result_t expected_results_q [$];
  palette_beat_t   next_beat;
  palette_result_t got_result;
  palette_result_t want_result;

  int beats_sent   = 0;
  int total_beats  = 1;
  int idle_phase   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  color_palette_ram_auto_index_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .target         (target),
    .data_byte      (data_byte),
    .palette_number (palette_number),
    .color_number   (color_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .color_rgba     (color_rgba),
    .index_value    (index_value)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] bgr555_to_rgba(input logic [15:0] w);
    return {w[4:0], 3'b000, w[9:5], 3'b000, w[14:10], 3'b000, 8'hFF};
  endfunction

  function automatic palette_result_t palette_step(input palette_beat_t b);
    palette_result_t r;
    logic [7:0]      idx;
    logic [4:0]      addr;
    logic [15:0]     w;
    r    = '0;
    idx  = pal_index[b.target];
    addr = idx[5:1];
    w    = pal_words[b.target][addr];
    case (b.cmd)
      CMD_WRITE_INDEX: begin
        idx = b.data;
      end
      CMD_WRITE_DATA: begin
        if (idx[IdxHighBit]) w[15:8] = b.data;
        else w[7:0] = b.data;
        pal_words[b.target][addr] = w;
        r.color_rgba = bgr555_to_rgba(w);
        if (idx[IdxAutoIncBit]) idx[5:0] = idx[5:0] + 6'd1;
      end
      CMD_READ_DATA: begin
        r.read_byte = idx[IdxHighBit] ? w[15:8] : w[7:0];
      end
      default: begin
        r.color_rgba = bgr555_to_rgba(pal_words[b.target][{b.pal, b.col}]);
      end
    endcase
    pal_index[b.target] = idx;
    r.index_value = idx;
    return r;
  endfunction

  function automatic int sender_idle_pct(input int ph);
    case (ph)
      1:       return 68;
      3:       return 14;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int ph);
    case (ph)
      2:       return 68;
      3:       return 14;
      default: return 0;
    endcase
  endfunction

  task automatic queue_beat(input command_t cmd, input logic tgt, input logic [7:0] d,
                            input logic [2:0] p, input logic [1:0] c);
    palette_beat_t b;
    b.cmd    = cmd;
    b.target = tgt;
    b.data   = d;
    b.pal    = p;
    b.col    = c;
    beat_q.push_back(b);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_beat.cmd    = command_t'(command);
        next_beat.target = target;
        next_beat.data   = data_byte;
        next_beat.pal    = palette_number;
        next_beat.col    = color_number;
        expected_results_q.push_back(palette_step(next_beat));
        beats_sent = beats_sent + 1;
        idle_phase <= (beats_sent * 4 / total_beats > 3) ? 3 : beats_sent * 4 / total_beats;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= sender_idle_pct(idle_phase)) begin
          next_beat = beat_q.pop_front();
          in_valid       <= 1'b1;
          command        <= next_beat.cmd;
          target         <= next_beat.target;
          data_byte      <= next_beat.data;
          palette_number <= next_beat.pal;
          color_number   <= next_beat.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < receiver_stall_pct(idle_phase));
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result.read_byte   = read_byte;
      got_result.color_rgba  = color_rgba;
      got_result.index_value = index_value;
      if (expected_results_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= ReportLimit)
          $display("unexpected result beat: read_byte %02h color_rgba %08h index_value %02h",
                   read_byte, color_rgba, index_value);
      end else begin
        want_result = expected_results_q.pop_front();
        if (got_result.read_byte !== want_result.read_byte ||
            got_result.color_rgba !== want_result.color_rgba ||
            got_result.index_value !== want_result.index_value) begin
          mismatches = mismatches + 1;
          if (mismatches <= ReportLimit)
            $display("mismatch: read_byte %02h/%02h color_rgba %08h/%08h index_value %02h/%02h",
                     want_result.read_byte, got_result.read_byte,
                     want_result.color_rgba, got_result.color_rgba,
                     want_result.index_value, got_result.index_value);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL color_palette_ram_auto_index_unit");
        $finish;
      end
    end
  end

  initial begin
    logic       tgt;
    logic [7:0] idx;
    int         len;
    for (int t = 0; t < 2; t++) begin
      pal_index[t] = 8'h00;
      for (int i = 0; i < 32; i++) pal_words[t][i] = 16'h0000;
    end

    // directed: reset contents, auto-increment, wrap, bit 6, both memories
    queue_beat(CMD_LOOKUP,      1'b0, 8'h00, 3'd7, 2'd3);
    queue_beat(CMD_WRITE_INDEX, 1'b0, 8'h80, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b0, 8'hFF, 3'd7, 2'd3);
    queue_beat(CMD_WRITE_DATA,  1'b0, 8'hFF, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_INDEX, 1'b0, 8'h01, 3'd0, 2'd0);
    queue_beat(CMD_READ_DATA,   1'b0, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b0, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_READ_DATA,   1'b0, 8'hFF, 3'd7, 2'd3);
    queue_beat(CMD_LOOKUP,      1'b0, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_INDEX, 1'b0, 8'hFF, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b0, 8'hAA, 3'd0, 2'd0);
    queue_beat(CMD_READ_DATA,   1'b0, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_INDEX, 1'b1, 8'h40, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b1, 8'h55, 3'd0, 2'd0);
    queue_beat(CMD_READ_DATA,   1'b1, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_READ_DATA,   1'b0, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_LOOKUP,      1'b1, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_LOOKUP,      1'b0, 8'h00, 3'd7, 2'd3);
    queue_beat(CMD_WRITE_INDEX, 1'b1, 8'hBE, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b1, 8'h1F, 3'd0, 2'd0);
    queue_beat(CMD_WRITE_DATA,  1'b1, 8'hE0, 3'd0, 2'd0);
    queue_beat(CMD_LOOKUP,      1'b1, 8'h00, 3'd7, 2'd3);
    queue_beat(CMD_READ_DATA,   1'b1, 8'h00, 3'd0, 2'd0);
    queue_beat(CMD_LOOKUP,      1'b0, 8'h00, 3'd0, 2'd0);

    // random: bursts through the auto-increment with read-back, plus loose commands
    while (beat_q.size() < RandomItems) begin
      if ($urandom_range(99) < 55) begin
        tgt = 1'($urandom_range(1));
        idx = 8'($urandom_range(255));
        if ($urandom_range(99) < 85) idx[IdxAutoIncBit] = 1'b1;
        len = $urandom_range(8, 1);
        queue_beat(CMD_WRITE_INDEX, tgt, idx, 3'($urandom_range(7)), 2'($urandom_range(3)));
        for (int k = 0; k < len; k++)
          queue_beat(CMD_WRITE_DATA, tgt, 8'($urandom_range(255)), 3'($urandom_range(7)),
                     2'($urandom_range(3)));
        for (int k = 0; k < len; k++) begin
          queue_beat(CMD_WRITE_INDEX, tgt, {idx[7:6], idx[5:0] + 6'(k)},
                     3'($urandom_range(7)), 2'($urandom_range(3)));
          queue_beat(CMD_READ_DATA, tgt, 8'($urandom_range(255)), 3'($urandom_range(7)),
                     2'($urandom_range(3)));
        end
        queue_beat(CMD_LOOKUP, tgt, 8'($urandom_range(255)), idx[5:3], idx[2:1]);
      end else begin
        queue_beat(command_t'($urandom_range(3)), 1'($urandom_range(1)),
                   8'($urandom_range(255)), 3'($urandom_range(7)), 2'($urandom_range(3)));
      end
    end
    total_beats = beat_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (beats_sent != total_beats || expected_results_q.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && expected_results_q.size() == 0) begin
      $display("PASS color_palette_ram_auto_index_unit");
    end else begin
      $display("FAIL color_palette_ram_auto_index_unit");
    end
    $finish;
  end

endmodule
